// File: rtl/tetp_pkg.sv
// shared types and constants of the timed event track player
package tetp_pkg;

    localparam int DEF_NUM_TRACKS = 16;
    localparam int DEF_EVENTS     = 256;
    localparam int TRK_W          = 4;
    localparam int SLOT_W         = 8;
    localparam int LEN_W          = 9;
    localparam int PT_W           = 40;
    localparam int Q_W            = 17;
    localparam int CNT_W          = 5;
    localparam int CFG_IDX_W      = 1;
    localparam logic [PT_W-1:0]  TIME_MAX = {PT_W{1'b1}};
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(Q_W - 1);

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_LENGTH  = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_RESTART = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_STICK   = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASK     = 1'b0,
        CFG_DURATION = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACT_RD,
        ST_ACT_EV,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_PEND_CHK,
        ST_PEND_EV,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             accept;
        logic             rd_act;
        logic             rd_pend;
        logic             act_end;
        logic             mul;
        logic             div_step;
        logic             fin;
        logic             pend_eval;
        logic             done;
        logic             comp;
        logic [TRK_W-1:0] trk;
    } t_cmd;

    typedef struct packed {
        logic act_valid;
        logic act_end;
        logic act_ramp;
        logic pend_valid;
    } t_sts;

endpackage

// File: rtl/tetp_ctrl.sv
// sequencing state machine: walks the tracks of a tick and steps the ramp divider
module tetp_ctrl #(
    parameter int NUM_TRACKS = tetp_pkg::DEF_NUM_TRACKS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_mode,
    input  tetp_pkg::t_sts i_sts,
    output tetp_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import tetp_pkg::*;

    localparam int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam logic [TW-1:0] TRK_LAST = TW'(NUM_TRACKS - 1);

    t_state           r_state, n_state;
    logic [TW-1:0]    r_trk, n_trk;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_comp, n_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_trk   <= '0;
            r_cnt   <= '0;
            r_comp  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_trk   <= n_trk;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_trk   = r_trk;
        n_cnt   = r_cnt;
        n_comp  = r_comp;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_mode == MODE_TICK) begin
                    n_trk   = '0;
                    n_state = ST_ACT_RD;
                end
            end
            ST_ACT_RD: begin
                n_state = i_sts.act_valid ? ST_ACT_EV : ST_PEND_CHK;
            end
            ST_ACT_EV: begin
                if (!i_sts.act_end && i_sts.act_ramp) begin
                    n_comp  = 1'b0;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_PEND_CHK;
                end
            end
            ST_MUL: begin
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FIN: begin
                if (!r_comp) begin
                    n_comp  = 1'b1;
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_PEND_CHK;
                end
            end
            ST_PEND_CHK: begin
                n_state = i_sts.pend_valid ? ST_PEND_EV : ST_NEXT;
            end
            ST_PEND_EV: begin
                n_state = ST_NEXT;
            end
            ST_NEXT: begin
                if (r_trk == TRK_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_trk   = r_trk + TW'(1);
                    n_state = ST_ACT_RD;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.trk  = TRK_W'(r_trk);
        o_cmd.comp = r_comp;
        unique case (r_state)
            ST_IDLE:     o_cmd.accept    = i_start;
            ST_ACT_RD:   o_cmd.rd_act    = i_sts.act_valid;
            ST_ACT_EV:   o_cmd.act_end   = i_sts.act_end;
            ST_MUL:      o_cmd.mul       = 1'b1;
            ST_DIV:      o_cmd.div_step  = 1'b1;
            ST_FIN:      o_cmd.fin       = 1'b1;
            ST_PEND_CHK: o_cmd.rd_pend   = i_sts.pend_valid;
            ST_PEND_EV:  o_cmd.pend_eval = 1'b1;
            ST_DONE:     o_cmd.done      = 1'b1;
            default:     o_cmd.accept    = 1'b0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// File: rtl/tetp_dp.sv
// datapath: event memory, per-track play state, ramp multiply and divide, result registers
module tetp_dp #(
    parameter int NUM_TRACKS       = tetp_pkg::DEF_NUM_TRACKS,
    parameter int EVENTS_PER_TRACK = tetp_pkg::DEF_EVENTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tetp_pkg::t_cmd                 i_cmd,
    output tetp_pkg::t_sts                 o_sts,
    input  logic                           i_cfg_valid,
    input  logic [tetp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic [1:0]                     i_mode,
    input  logic [tetp_pkg::TRK_W-1:0]     i_track,
    input  logic [tetp_pkg::SLOT_W-1:0]    i_event_index,
    input  logic [31:0]                    i_event_time,
    input  logic [31:0]                    i_event_duration,
    input  logic signed [15:0]             i_target_angle,
    input  logic [15:0]                    i_target_distance,
    input  logic [tetp_pkg::LEN_W-1:0]     i_track_length,
    input  logic [31:0]                    i_time_delta,
    output logic                           o_valid,
    output logic [1:0]                     o_kind,
    output logic [tetp_pkg::TRK_W-1:0]     o_out_track,
    output logic signed [15:0]             o_angle,
    output logic [15:0]                    o_distance,
    output logic [tetp_pkg::PT_W-1:0]      o_play_time,
    output logic                           o_finished,
    output logic                           o_last
);
    import tetp_pkg::*;

    localparam int TW    = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;
    localparam int EW    = (EVENTS_PER_TRACK > 1) ? $clog2(EVENTS_PER_TRACK) : 1;
    localparam int CW    = $clog2(EVENTS_PER_TRACK + 1);
    localparam int AW    = TW + EW;
    localparam int DEPTH = 1 << AW;

    logic [95:0]           r_mem [DEPTH];
    logic [95:0]           r_rd;
    logic [NUM_TRACKS-1:0] r_mask;
    logic [31:0]           r_sdur;
    logic [PT_W-1:0]       r_pt;

    logic [CW-1:0]         r_count    [NUM_TRACKS];
    logic                  r_act_v    [NUM_TRACKS];
    logic [EW-1:0]         r_act_idx  [NUM_TRACKS];
    logic                  r_pend_v   [NUM_TRACKS];
    logic [EW-1:0]         r_pend_idx [NUM_TRACKS];
    logic signed [15:0]    r_cur_ang  [NUM_TRACKS];
    logic [15:0]           r_cur_dist [NUM_TRACKS];
    logic signed [15:0]    r_rs_ang   [NUM_TRACKS];
    logic [15:0]           r_rs_dist  [NUM_TRACKS];

    logic signed [17:0]    r_from;
    logic                  r_neg;
    logic [31:0]           r_rem;
    logic [Q_W-1:0]        r_q;
    logic signed [15:0]    r_new_ang;

    logic                  r_valid;
    t_kind                 r_kind;
    logic [TRK_W-1:0]      r_otrk;
    logic signed [15:0]    r_oang;
    logic [15:0]           r_odist;
    logic                  r_last;

    logic [TW-1:0]         trk;
    logic                  stick;
    logic [31:0]           ev_time, ev_dur;
    logic signed [15:0]    ev_ang;
    logic [15:0]           ev_dist;
    logic [PT_W-1:0]       ev_end;
    logic                  ended, due;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic                  wr_ok, len_ok;
    logic [CW-1:0]         len_sat;
    logic [PT_W:0]         pt_sum;
    logic [PT_W-1:0]       pt_next;
    logic signed [17:0]    to_val, from_val, diff;
    logic [16:0]           mag;
    logic [PT_W-1:0]       el_full;
    logic [31:0]           el;
    logic [48:0]           prod;
    logic [32:0]           trial;
    logic                  qbit;
    logic signed [17:0]    ramp_val;
    logic [CW-1:0]         nxt_idx;

    assign trk      = i_cmd.trk[TW-1:0];
    assign stick    = r_mask[trk];
    assign ev_time  = r_rd[95:64];
    assign ev_dur   = r_rd[63:32];
    assign ev_ang   = r_rd[31:16];
    assign ev_dist  = r_rd[15:0];
    assign ev_end   = PT_W'({1'b0, ev_time} + {1'b0, ev_dur});
    assign ended    = (r_pt >= ev_end);
    assign due      = (r_pt >= PT_W'(ev_time));

    assign wr_addr = {i_track[TW-1:0], i_event_index[EW-1:0]};
    assign rd_addr = {trk, i_cmd.rd_act ? r_act_idx[trk] : r_pend_idx[trk]};
    assign wr_ok   = ((TRK_W + 1)'(i_track) < (TRK_W + 1)'(NUM_TRACKS))
                  && ((SLOT_W + 1)'(i_event_index) < (SLOT_W + 1)'(EVENTS_PER_TRACK));
    assign len_ok  = ((TRK_W + 1)'(i_track) < (TRK_W + 1)'(NUM_TRACKS));
    assign len_sat = (i_track_length > LEN_W'(EVENTS_PER_TRACK))
                   ? CW'(EVENTS_PER_TRACK) : CW'(i_track_length);

    assign pt_sum  = {1'b0, r_pt} + (PT_W + 1)'(i_time_delta);
    assign pt_next = (pt_sum > {1'b0, TIME_MAX}) ? TIME_MAX : pt_sum[PT_W-1:0];

    assign to_val   = i_cmd.comp ? 18'(signed'({2'b00, ev_dist})) : 18'(ev_ang);
    assign from_val = i_cmd.comp ? 18'(signed'({2'b00, r_rs_dist[trk]}))
                                 : 18'(r_rs_ang[trk]);
    assign diff     = to_val - from_val;
    assign mag      = diff[17] ? 17'(-diff) : diff[16:0];
    assign el_full  = (r_pt > PT_W'(ev_time)) ? (r_pt - PT_W'(ev_time)) : '0;
    assign el       = el_full[31:0];
    assign prod     = 49'(mag) * 49'(el);

    assign trial    = {r_rem, r_q[Q_W-1]};
    assign qbit     = (trial >= {1'b0, ev_dur});
    assign ramp_val = r_neg ? (r_from - 18'(signed'({1'b0, r_q})))
                            : (r_from + 18'(signed'({1'b0, r_q})));
    assign nxt_idx  = CW'(r_act_idx[trk]) + CW'(1);

    assign o_sts.act_valid  = r_act_v[trk];
    assign o_sts.act_end    = ended;
    assign o_sts.act_ramp   = stick && (ev_dur != '0);
    assign o_sts.pend_valid = r_pend_v[trk];

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_mode == MODE_WRITE && wr_ok) begin
            r_mem[wr_addr] <= {i_event_time, i_event_duration, i_target_angle,
                               i_target_distance};
        end
        if (i_cmd.rd_act || i_cmd.rd_pend) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_from <= from_val;
            r_neg  <= diff[17];
            r_rem  <= prod[48:17];
            r_q    <= prod[16:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= qbit ? 32'(trial - {1'b0, ev_dur}) : trial[31:0];
            r_q   <= {r_q[Q_W-2:0], qbit};
        end
        if (i_cmd.fin && !i_cmd.comp) begin
            r_new_ang <= ramp_val[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_sdur  <= '0;
            r_pt    <= '0;
            r_valid <= 1'b0;
            r_kind  <= KIND_DONE;
            r_otrk  <= '0;
            r_oang  <= '0;
            r_odist <= '0;
            r_last  <= 1'b0;
            for (int t = 0; t < NUM_TRACKS; t++) begin
                r_count[t]    <= '0;
                r_act_v[t]    <= 1'b0;
                r_act_idx[t]  <= '0;
                r_pend_v[t]   <= 1'b0;
                r_pend_idx[t] <= '0;
                r_cur_ang[t]  <= '0;
                r_cur_dist[t] <= '0;
                r_rs_ang[t]   <= '0;
                r_rs_dist[t]  <= '0;
            end
        end else begin
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MASK:     r_mask <= i_cfg_data[NUM_TRACKS-1:0];
                    CFG_DURATION: r_sdur <= i_cfg_data;
                    default:      r_sdur <= r_sdur;
                endcase
            end
            if (i_cmd.accept) begin
                unique case (i_mode)
                    MODE_LENGTH: begin
                        if (len_ok) begin
                            r_count[i_track[TW-1:0]] <= len_sat;
                        end
                    end
                    MODE_TICK: begin
                        r_pt <= pt_next;
                    end
                    MODE_RESTART: begin
                        r_pt <= '0;
                        for (int t = 0; t < NUM_TRACKS; t++) begin
                            r_act_v[t]    <= 1'b0;
                            r_act_idx[t]  <= '0;
                            r_pend_v[t]   <= (r_count[t] != '0);
                            r_pend_idx[t] <= '0;
                            r_cur_ang[t]  <= '0;
                            r_cur_dist[t] <= '0;
                            r_rs_ang[t]   <= '0;
                            r_rs_dist[t]  <= '0;
                        end
                    end
                    default: begin
                        r_pt <= r_pt;
                    end
                endcase
            end
            if (i_cmd.act_end) begin
                r_valid <= 1'b1;
                r_otrk  <= TRK_W'(trk);
                if (stick) begin
                    r_cur_ang[trk]  <= ev_ang;
                    r_cur_dist[trk] <= ev_dist;
                    r_kind  <= KIND_STICK;
                    r_oang  <= ev_ang;
                    r_odist <= ev_dist;
                end else begin
                    r_kind  <= KIND_RELEASE;
                    r_oang  <= '0;
                    r_odist <= '0;
                end
                if (nxt_idx < r_count[trk]) begin
                    r_pend_v[trk]   <= 1'b1;
                    r_pend_idx[trk] <= nxt_idx[EW-1:0];
                end else begin
                    r_pend_v[trk] <= 1'b0;
                end
                r_act_v[trk] <= 1'b0;
            end
            if (i_cmd.fin && i_cmd.comp) begin
                r_cur_ang[trk]  <= r_new_ang;
                r_cur_dist[trk] <= ramp_val[15:0];
                r_valid <= 1'b1;
                r_kind  <= KIND_STICK;
                r_otrk  <= TRK_W'(trk);
                r_oang  <= r_new_ang;
                r_odist <= ramp_val[15:0];
            end
            if (i_cmd.pend_eval && due) begin
                if (stick) begin
                    if (ev_dur != '0) begin
                        r_rs_ang[trk]  <= r_cur_ang[trk];
                        r_rs_dist[trk] <= r_cur_dist[trk];
                    end else begin
                        r_cur_ang[trk]  <= ev_ang;
                        r_cur_dist[trk] <= ev_dist;
                        r_valid <= 1'b1;
                        r_kind  <= KIND_STICK;
                        r_otrk  <= TRK_W'(trk);
                        r_oang  <= ev_ang;
                        r_odist <= ev_dist;
                    end
                end else begin
                    r_valid <= 1'b1;
                    r_kind  <= KIND_PRESS;
                    r_otrk  <= TRK_W'(trk);
                    r_oang  <= '0;
                    r_odist <= '0;
                end
                r_act_v[trk]   <= 1'b1;
                r_act_idx[trk] <= r_pend_idx[trk];
                r_pend_v[trk]  <= 1'b0;
            end
            if (i_cmd.done) begin
                r_valid <= 1'b1;
                r_kind  <= KIND_DONE;
                r_otrk  <= '0;
                r_oang  <= '0;
                r_odist <= '0;
                r_last  <= 1'b1;
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_kind      = r_kind;
    assign o_out_track = r_otrk;
    assign o_angle     = r_oang;
    assign o_distance  = r_odist;
    assign o_play_time = r_pt;
    assign o_finished  = (r_pt >= PT_W'(r_sdur));
    assign o_last      = r_last;

endmodule

// File: rtl/timed_event_track_player_core.sv
// top level of the timed event track player
//
// usage: an item is accepted at a rising edge with i_start high and o_busy low.
// write event, set length and restart give no result and leave o_busy low.
// a tick advances playback time (saturating at 2^40-1), then walks the tracks
// from 0 upward: each track ends its active event and starts its next one,
// and every stick update, button press and button release is one result.
// a final result with o_last high closes the tick.
// each result is on the o_ ports for exactly one cycle, marked by o_valid;
// the receiver cannot stall, so none is held back.
// each stick ramp takes one 17x32 multiply and 17 one-bit divide steps, for angle
// and distance in turn on the shared divider.
// o_busy is high for the whole tick; the next item waits for it to drop.
// configuration: i_cfg_valid with i_cfg_index and i_cfg_data, always ready.
// synchronous active-low reset clears play state, lengths and result registers;
// event memory holds whatever was written and needs no clearing.
module timed_event_track_player_core #(
    parameter int NUM_TRACKS       = tetp_pkg::DEF_NUM_TRACKS,
    parameter int EVENTS_PER_TRACK = tetp_pkg::DEF_EVENTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_mode,
    input  logic [tetp_pkg::TRK_W-1:0]     i_track,
    input  logic [tetp_pkg::SLOT_W-1:0]    i_event_index,
    input  logic [31:0]                    i_event_time,
    input  logic [31:0]                    i_event_duration,
    input  logic signed [15:0]             i_target_angle,
    input  logic [15:0]                    i_target_distance,
    input  logic [tetp_pkg::LEN_W-1:0]     i_track_length,
    input  logic [31:0]                    i_time_delta,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tetp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    output logic                           o_valid,
    output logic [1:0]                     o_kind,
    output logic [tetp_pkg::TRK_W-1:0]     o_out_track,
    output logic signed [15:0]             o_angle,
    output logic [15:0]                    o_distance,
    output logic [tetp_pkg::PT_W-1:0]      o_play_time,
    output logic                           o_finished,
    output logic                           o_last
);
    import tetp_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic busy;

    tetp_ctrl #(
        .NUM_TRACKS (NUM_TRACKS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start && !busy),
        .i_mode  (i_mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tetp_dp #(
        .NUM_TRACKS       (NUM_TRACKS),
        .EVENTS_PER_TRACK (EVENTS_PER_TRACK)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_mode            (i_mode),
        .i_track           (i_track),
        .i_event_index     (i_event_index),
        .i_event_time      (i_event_time),
        .i_event_duration  (i_event_duration),
        .i_target_angle    (i_target_angle),
        .i_target_distance (i_target_distance),
        .i_track_length    (i_track_length),
        .i_time_delta      (i_time_delta),
        .o_valid           (o_valid),
        .o_kind            (o_kind),
        .o_out_track       (o_out_track),
        .o_angle           (o_angle),
        .o_distance        (o_distance),
        .o_play_time       (o_play_time),
        .o_finished        (o_finished),
        .o_last            (o_last)
    );

    assign o_busy      = busy;
    assign o_cfg_ready = 1'b1;

endmodule

// File: bench/tb_top.sv
// self-checking testbench for the timed event track player core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tetp_pkg::*;

    localparam int NT = 16;
    localparam int NE = 256;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        t_mode       mode;
        logic [3:0]  trk;
        logic [7:0]  slot;
        logic [31:0] etime;
        logic [31:0] edur;
        logic [15:0] ang;
        logic [15:0] distance;
        logic [8:0]  len;
        logic [31:0] delta;
    } t_item;

    typedef struct {
        t_kind       kind;
        logic [3:0]  trk;
        logic [15:0] ang;
        logic [15:0] distance;
        logic [39:0] play;
        logic        fin;
        logic        last;
    } t_update;

    typedef struct {
        t_item       it;
        bit          typed;
        logic [39:0] typed_play;
    } t_row;

    logic i_clk = 0, i_rst_n = 0, i_start = 0;
    logic [1:0] i_mode = 0;
    logic [3:0] i_track = 0;
    logic [7:0] i_event_index = 0;
    logic [31:0] i_event_time = 0, i_event_duration = 0, i_time_delta = 0;
    logic signed [15:0] i_target_angle = 0;
    logic [15:0] i_target_distance = 0;
    logic [8:0] i_track_length = 0;
    logic i_cfg_valid = 0;
    logic [0:0] i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;
    logic o_busy, o_cfg_ready, o_valid, o_finished, o_last;
    logic [1:0] o_kind;
    logic [3:0] o_out_track;
    logic signed [15:0] o_angle;
    logic [15:0] o_distance;
    logic [39:0] o_play_time;

    timed_event_track_player_core dut (.*);

    // player state as predicted
    logic [31:0] ev_time [NT*NE];
    logic [31:0] ev_dur  [NT*NE];
    int          ev_ang  [NT*NE];
    int          ev_dist [NT*NE];
    bit          ev_written [NT*NE];
    int          trk_len [NT];
    bit          act_v [NT];
    int          act_ev [NT];
    bit          pend_v [NT];
    int          pend_ev [NT];
    int          cur_ang [NT], cur_dist [NT], ramp_ang [NT], ramp_dist [NT];
    longint unsigned play_time_model;
    logic [15:0] stick_mask;
    logic [31:0] script_len;

    t_update expected_updates[$];
    int errors = 0, items_sent = 0, updates_checked = 0, gap_pct = 0;
    longint cycles = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [15:0] ramp_val(int from, int to,
                                             longint unsigned el, longint unsigned dur);
        longint diff;
        longint unsigned mag, q;
        diff = longint'(to) - longint'(from);
        mag  = diff < 0 ? -diff : diff;
        q    = mag * el / dur;
        return diff < 0 ? 16'(longint'(from) - longint'(q)) : 16'(longint'(from) + longint'(q));
    endfunction

    function automatic void push_update(t_kind k, int t, int a, int d, bit l);
        t_update u;
        u.kind     = k;
        u.trk      = 4'(t);
        u.ang      = 16'(a);
        u.distance = 16'(d);
        u.play     = 40'(play_time_model);
        u.fin      = play_time_model >= longint'(script_len);
        u.last     = l;
        expected_updates.push_back(u);
    endfunction

    function automatic void restart_model();
        play_time_model = 0;
        for (int t = 0; t < NT; t++) begin
            act_v[t] = 0; act_ev[t] = 0;
            pend_v[t] = trk_len[t] > 0; pend_ev[t] = 0;
            cur_ang[t] = 0; cur_dist[t] = 0; ramp_ang[t] = 0; ramp_dist[t] = 0;
        end
    endfunction

    // advance the predicted player by one accepted transaction
    function automatic void apply_item(t_item it);
        int a;
        bit stick;
        longint unsigned st, dur, el;
        case (it.mode)
            MODE_WRITE: begin
                a = it.trk * NE + it.slot;
                ev_time[a] = it.etime;
                ev_dur[a]  = it.edur;
                ev_ang[a]  = int'($signed(it.ang));
                ev_dist[a] = int'(it.distance);
                ev_written[a] = 1;
            end
            MODE_LENGTH: trk_len[it.trk] = it.len > NE ? NE : int'(it.len);
            MODE_RESTART: restart_model();
            MODE_TICK: begin
                play_time_model += it.delta;
                if (play_time_model > 64'(TIME_MAX)) play_time_model = 64'(TIME_MAX);
                for (int t = 0; t < NT; t++) begin
                    stick = stick_mask[t];
                    if (act_v[t]) begin
                        a = t * NE + act_ev[t];
                        st = ev_time[a];
                        dur = ev_dur[a];
                        if (play_time_model >= st + dur) begin
                            if (stick) begin
                                cur_ang[t] = ev_ang[a];
                                cur_dist[t] = ev_dist[a];
                                push_update(KIND_STICK, t, cur_ang[t], cur_dist[t], 0);
                            end else begin
                                push_update(KIND_RELEASE, t, 0, 0, 0);
                            end
                            pend_v[t] = act_ev[t] + 1 < trk_len[t];
                            if (pend_v[t]) pend_ev[t] = act_ev[t] + 1;
                            act_v[t] = 0;
                        end else if (stick && dur > 0) begin
                            el = play_time_model > st ? play_time_model - st : 0;
                            cur_ang[t] = int'($signed(ramp_val(ramp_ang[t], ev_ang[a], el, dur)));
                            cur_dist[t] = int'(ramp_val(ramp_dist[t], ev_dist[a], el, dur));
                            push_update(KIND_STICK, t, cur_ang[t], cur_dist[t], 0);
                        end
                    end
                    if (pend_v[t]) begin
                        a = t * NE + pend_ev[t];
                        if (play_time_model >= longint'(ev_time[a])) begin
                            if (stick) begin
                                if (ev_dur[a] > 0) begin
                                    ramp_ang[t] = cur_ang[t];
                                    ramp_dist[t] = cur_dist[t];
                                end else begin
                                    cur_ang[t] = ev_ang[a];
                                    cur_dist[t] = ev_dist[a];
                                    push_update(KIND_STICK, t, cur_ang[t], cur_dist[t], 0);
                                end
                            end else begin
                                push_update(KIND_PRESS, t, 0, 0, 0);
                            end
                            act_v[t] = 1;
                            act_ev[t] = pend_ev[t];
                            pend_v[t] = 0;
                        end
                    end
                end
                push_update(KIND_DONE, 0, 0, 0, 1);
            end
        endcase
    endfunction

    function automatic int written_prefix(int t);
        int n = 0;
        while (n < NE && ev_written[t*NE + n]) n++;
        return n;
    endfunction

    // called at a rising edge; returns at the edge that accepts the transaction
    task automatic send(t_item it, bit typed = 0, logic [39:0] typed_play = 0);
        t_update u;
        if ($urandom_range(99) < gap_pct) begin
            i_start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_start <= 1;
        i_mode <= it.mode; i_track <= it.trk; i_event_index <= it.slot;
        i_event_time <= it.etime; i_event_duration <= it.edur;
        i_target_angle <= it.ang; i_target_distance <= it.distance;
        i_track_length <= it.len; i_time_delta <= it.delta;
        forever begin
            @(negedge i_clk);
            if (!o_busy) break;
        end
        @(posedge i_clk);
        items_sent++;
        if (typed) begin
            play_time_model = typed_play;
            u = '{KIND_DONE, 0, 0, 0, typed_play, 1'b1, 1'b1};
            expected_updates.push_back(u);
        end else begin
            apply_item(it);
        end
    endtask

    task automatic drain();
        i_start <= 0;
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // called at a rising edge; returns at a rising edge after the accepting edge, with i_cfg_valid low
    task automatic cfg_write(t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        if (idx == CFG_MASK) stick_mask = data[15:0];
        else script_len = data;
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        t_update e;
        if (i_rst_n && o_valid) begin
            updates_checked++;
            if (expected_updates.size() == 0) begin
                $error("unexpected result kind %0d track %0d", o_kind, o_out_track);
                errors++;
            end else begin
                e = expected_updates.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind: expected %0d actual %0d", e.kind, o_kind); errors++;
                end
                if (o_out_track !== e.trk) begin
                    $error("out_track: expected %0d actual %0d", e.trk, o_out_track); errors++;
                end
                if (o_angle !== e.ang) begin
                    $error("angle: expected %h actual %h", e.ang, o_angle); errors++;
                end
                if (o_distance !== e.distance) begin
                    $error("distance: expected %h actual %h", e.distance, o_distance);
                    errors++;
                end
                if (o_play_time !== e.play) begin
                    $error("play_time: expected %h actual %h", e.play, o_play_time); errors++;
                end
                if (o_finished !== e.fin) begin
                    $error("finished: expected %b actual %b", e.fin, o_finished); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %b actual %b", e.last, o_last); errors++;
                end
            end
        end
    end

    function automatic t_item mk(t_mode m, int t = 0, int s = 0, logic [31:0] et = 0,
                                 logic [31:0] ed = 0, logic [15:0] an = 0,
                                 logic [15:0] di = 0, int ln = 0, logic [31:0] dt = 0);
        t_item it;
        it = '{m, 4'(t), 8'(s), et, ed, an, di, 9'(ln), dt};
        return it;
    endfunction

    function automatic t_item rand_noise();
        t_item it;
        int t;
        it = mk(t_mode'($urandom_range(3)), $urandom_range(15), $urandom_range(255),
                $urandom, $urandom, 16'($urandom), 16'($urandom), 0, $urandom_range(300));
        t = it.trk;
        if (it.mode == MODE_LENGTH) it.len = 9'($urandom_range(0, written_prefix(t)));
        if (it.mode == MODE_WRITE && $urandom_range(1)) it.etime = $urandom_range(3000);
        return it;
    endfunction

    task automatic scene();
        int ntr, t, k, tm;
        t_item it;
        ntr = $urandom_range(1, 5);
        for (int i = 0; i < ntr; i++) begin
            t = $urandom_range(15);
            k = $urandom_range(1, 6);
            tm = $urandom_range(200);
            for (int s = 0; s < k; s++) begin
                it = mk(MODE_WRITE, t, s, tm, $urandom_range(3) == 0 ? 0 : $urandom_range(1, 400),
                        16'($urandom), 16'($urandom));
                if ($urandom_range(19) == 0) it.edur = $urandom;
                if ($urandom_range(29) == 0) it.etime = $urandom;
                send(it);
                tm += $urandom_range(300);
            end
            send(mk(MODE_LENGTH, t, 0, 0, 0, 0, 0, $urandom_range(0, written_prefix(t))));
        end
        send(mk(MODE_RESTART));
        repeat ($urandom_range(5, 20)) begin
            it = mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, $urandom_range(150));
            if ($urandom_range(29) == 0) it.delta = $urandom;
            send(it);
        end
        if ($urandom_range(2) == 0) send(rand_noise());
    endtask

    initial begin
        t_row rows[$];
        int phase_gap[4] = '{0, 48, 0, 31};
        logic [15:0] masks[4] = '{16'h0000, 16'hFFFF, 16'h5A3C, 16'hFFFF};
        logic [31:0] lens[4] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'd2000, 32'd500};
        int target;

        for (int i = 0; i < NT*NE; i++) ev_written[i] = 0;
        for (int t = 0; t < NT; t++) trk_len[t] = 0;
        stick_mask = 0;
        script_len = 0;
        restart_model();
        for (int t = 0; t < NT; t++) pend_v[t] = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed part: typed rows carry the tick done result of an empty player
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 1, 40'd0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 1,
                         40'h00_FFFF_FFFF});
        rows.push_back('{mk(MODE_RESTART), 0, 0});
        rows.push_back('{mk(MODE_WRITE, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(MODE_WRITE, 0, 1, 10, 20), 0, 0});
        rows.push_back('{mk(MODE_WRITE, 1, 0, 5, 100, 16'h7FFF, 16'hFFFF), 0, 0});
        rows.push_back('{mk(MODE_WRITE, 1, 1, 200, 0, 16'h8000, 16'h0000), 0, 0});
        rows.push_back('{mk(MODE_WRITE, 1, 2, 250, 90, 16'hFFFF, 16'h1234), 0, 0});
        rows.push_back('{mk(MODE_WRITE, 15, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                            16'hFFFF), 0, 0});
        rows.push_back('{mk(MODE_LENGTH, 0, 0, 0, 0, 0, 0, 511), 0, 0});
        rows.push_back('{mk(MODE_LENGTH, 0, 0, 0, 0, 0, 0, 2), 0, 0});
        rows.push_back('{mk(MODE_LENGTH, 1, 0, 0, 0, 0, 0, 2), 0, 0});
        rows.push_back('{mk(MODE_RESTART), 0, 0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 7), 0, 0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 33), 0, 0});
        rows.push_back('{mk(MODE_LENGTH, 1, 0, 0, 0, 0, 0, 3), 0, 0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 70), 0, 0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 150), 0, 0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 80), 0, 0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 0, 0});
        rows.push_back('{mk(MODE_RESTART), 0, 0});
        rows.push_back('{mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 300), 0, 0});

        cfg_write(CFG_MASK, 32'h0000_0002);
        cfg_write(CFG_DURATION, 32'd0);
        foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].typed_play);
        drain();

        // random part in phases with changing settings and sender gaps
        for (int p = 0; p < 4; p++) begin
            cfg_write(CFG_MASK, p == 2 ? 32'($urandom) : 32'(masks[p]));
            cfg_write(CFG_DURATION, p == 3 ? $urandom_range(3000) : lens[p]);
            gap_pct = phase_gap[p];
            target = items_sent + 25;
            while (items_sent < target) begin
                if ($urandom_range(9) == 0) send(rand_noise());
                else scene();
            end
            drain();
        end

        // time saturation: long run of maximal ticks over loaded tracks
        gap_pct = 0;
        scene();
        repeat (258) send(mk(MODE_TICK, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
        drain();

        $display("covered %0d transactions, %0d results checked, %0d mismatches",
                 items_sent, updates_checked, errors);
        if (errors == 0 && expected_updates.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
